[hw/rtl/brcs_pkg.sv]
`default_nettype none

package brcs_pkg;

  // field widths
  localparam int PIX_W      = 10;
  localparam int VAL_W      = PIX_W - 2;
  localparam int COORD_W    = 12;
  localparam int ORDER_W    = 2;
  localparam int BLC_W      = 8;
  localparam int SUM_W      = 30;
  localparam int CNT_W      = 23;
  localparam int AVG_W      = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_BOTTOM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAYER_ORDER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 3'd5;

  // accumulator limits
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // pixel item queue between classifier and accumulator
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // colour channel of a quad position
  typedef enum logic [1:0] {
    CH_RED     = 2'd0,
    CH_GREEN_R = 2'd1,
    CH_GREEN_B = 2'd2,
    CH_BLUE    = 2'd3
  } chan_t;

  // classified pixel item
  typedef struct packed {
    logic [VAL_W-1:0] value;
    chan_t            chan;
    logic             in_roi;
    logic             quad;
    logic             eof;
  } pix_item_t;

  // frame totals handed to the statistics unit
  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green_r;
    logic [SUM_W-1:0] sum_green_b;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] quad_count;
  } frame_sums_t;

  // one statistics result
  typedef struct packed {
    logic [AVG_W-1:0] avg_red;
    logic [AVG_W-1:0] avg_green_r;
    logic [AVG_W-1:0] avg_green_b;
    logic [AVG_W-1:0] avg_blue;
    logic [AVG_W-1:0] avg_green;
    logic [AVG_W-1:0] luma;
    logic [AVG_W-1:0] red_gain;
    logic [AVG_W-1:0] blue_gain;
    logic [CNT_W-1:0] quad_count;
    logic             gains_valid;
    logic             roi_empty;
  } stats_result_t;

endpackage

`default_nettype wire

[hw/rtl/brcs_front.sv]
`default_nettype none

module brcs_front (
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [brcs_pkg::PIX_W-1:0]      raw_pixel,
  input  wire logic [brcs_pkg::COORD_W-1:0]    column,
  input  wire logic [brcs_pkg::COORD_W-1:0]    row,
  input  wire logic                            end_of_frame,
  input  wire logic [brcs_pkg::COORD_W-1:0]    roi_left,
  input  wire logic [brcs_pkg::COORD_W-1:0]    roi_top,
  input  wire logic [brcs_pkg::COORD_W-1:0]    roi_right,
  input  wire logic [brcs_pkg::COORD_W-1:0]    roi_bottom,
  input  wire logic [brcs_pkg::ORDER_W-1:0]    bayer_order,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output brcs_pkg::pix_item_t                  q_item
);
  import brcs_pkg::*;

  logic               col_ok;
  logic               row_ok;
  logic [ORDER_W-1:0] pos;

  // take an item whenever the queue has room and reset is released
  assign in_stall = q_full || !rst_n;
  assign q_push   = in_valid && !in_stall;

  // region test: left/top bound on the pixel, right/bottom on the quad start
  always_comb begin
    col_ok = (column >= roi_left) && ({column[COORD_W-1:1], 1'b0} < roi_right);
    row_ok = (row >= roi_top) && ({row[COORD_W-1:1], 1'b0} < roi_bottom);
    pos    = {row[0], column[0]} ^ bayer_order;
  end

  // classified item
  always_comb begin
    q_item.value  = raw_pixel[PIX_W-1:PIX_W-VAL_W];
    q_item.chan   = chan_t'(pos);
    q_item.in_roi = col_ok && row_ok;
    q_item.quad   = !column[0] && !row[0];
    q_item.eof    = end_of_frame;
  end

endmodule

`default_nettype wire

[hw/rtl/brcs_queue.sv]
`default_nettype none

module brcs_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire brcs_pkg::pix_item_t   push_item,
  output logic                       full,
  input  wire logic                  pop,
  output brcs_pkg::pix_item_t        head_item,
  output logic                       head_valid
);
  import brcs_pkg::*;

  pix_item_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full       = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/brcs_accum.sv]
`default_nettype none

module brcs_accum (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire brcs_pkg::pix_item_t   q_item,
  output logic                       q_pop,
  input  wire logic                  st_busy,
  output logic                       st_start,
  output brcs_pkg::frame_sums_t      st_sums
);
  import brcs_pkg::*;

  logic [SUM_W-1:0] red_r, red_nxt;
  logic [SUM_W-1:0] gr_r, gr_nxt;
  logic [SUM_W-1:0] gb_r, gb_nxt;
  logic [SUM_W-1:0] blue_r, blue_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             add_en;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [VAL_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // an end-of-frame item waits until the statistics unit is free
  assign q_pop    = q_valid && !(q_item.eof && st_busy);
  assign st_start = q_pop && q_item.eof;
  assign add_en   = q_pop && q_item.in_roi;

  // updated totals including the current item
  always_comb begin
    st_sums.sum_red     = red_r;
    st_sums.sum_green_r = gr_r;
    st_sums.sum_green_b = gb_r;
    st_sums.sum_blue    = blue_r;
    st_sums.quad_count  = cnt_r;
    if (add_en) begin
      unique case (q_item.chan)
        CH_RED:     st_sums.sum_red     = sat_add(red_r, q_item.value);
        CH_GREEN_R: st_sums.sum_green_r = sat_add(gr_r, q_item.value);
        CH_GREEN_B: st_sums.sum_green_b = sat_add(gb_r, q_item.value);
        CH_BLUE:    st_sums.sum_blue    = sat_add(blue_r, q_item.value);
      endcase
      if (q_item.quad && (cnt_r != CNT_MAX)) begin
        st_sums.quad_count = cnt_r + 1'b1;
      end
    end
  end

  // clear after the frame totals are handed over
  always_comb begin
    if (st_start) begin
      red_nxt  = '0;
      gr_nxt   = '0;
      gb_nxt   = '0;
      blue_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      red_nxt  = st_sums.sum_red;
      gr_nxt   = st_sums.sum_green_r;
      gb_nxt   = st_sums.sum_green_b;
      blue_nxt = st_sums.sum_blue;
      cnt_nxt  = st_sums.quad_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r  <= '0;
      gr_r   <= '0;
      gb_r   <= '0;
      blue_r <= '0;
      cnt_r  <= '0;
    end else begin
      red_r  <= red_nxt;
      gr_r   <= gr_nxt;
      gb_r   <= gb_nxt;
      blue_r <= blue_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/brcs_stats.sv]
`default_nettype none

module brcs_stats (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire brcs_pkg::frame_sums_t         sums,
  input  wire logic [brcs_pkg::BLC_W-1:0]    black_level,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output brcs_pkg::stats_result_t            result
);
  import brcs_pkg::*;

  localparam int GSUM_W      = SUM_W + 1;
  localparam int BLC_CNT_W   = BLC_W + CNT_W;
  localparam int CMP_W       = BLC_CNT_W + 2;
  localparam int DVS_W       = GSUM_W;
  localparam int AVG_SHIFT   = 8;
  localparam int GREEN_SHIFT = 7;
  localparam int GAIN_SHIFT  = 10;
  localparam int DVD_W       = SUM_W + GAIN_SHIFT + 1;
  localparam int STEP_W      = 6;
  localparam int NUM_JOBS    = 7;
  localparam int JOB_W       = 3;
  localparam int LUMA_SHIFT  = 10;
  localparam int LUMA_ACC_W  = AVG_W + LUMA_SHIFT;
  localparam int LUMA_WR     = 306;
  localparam int LUMA_WG     = 601;
  localparam int LUMA_WB     = 117;
  localparam int LUMA_RND    = 512;

  localparam logic [JOB_W-1:0] JOB_RED        = 3'd0;
  localparam logic [JOB_W-1:0] JOB_GREEN_R    = 3'd1;
  localparam logic [JOB_W-1:0] JOB_GREEN_B    = 3'd2;
  localparam logic [JOB_W-1:0] JOB_BLUE       = 3'd3;
  localparam logic [JOB_W-1:0] JOB_GREEN      = 3'd4;
  localparam logic [JOB_W-1:0] JOB_RED_GAIN   = 3'd5;
  localparam logic [JOB_W-1:0] JOB_BLUE_GAIN  = 3'd6;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_BLC    = 9'b000000010,
    ST_PREP   = 9'b000000100,
    ST_LOAD   = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_LUMA_R = 9'b000100000,
    ST_LUMA_G = 9'b001000000,
    ST_LUMA_B = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  frame_sums_t           sums_r, sums_nxt;
  logic [GSUM_W-1:0]     gsum_r, gsum_nxt;
  logic [BLC_CNT_W-1:0]  blc_cnt_r, blc_cnt_nxt;
  logic [DVS_W-1:0]      den_r, den_nxt;
  logic                  gain_ok_r, gain_ok_nxt;
  logic                  red_pos_r, red_pos_nxt;
  logic                  blue_pos_r, blue_pos_nxt;
  logic [SUM_W-1:0]      red_diff_r, red_diff_nxt;
  logic [SUM_W-1:0]      blue_diff_r, blue_diff_nxt;
  logic [JOB_W-1:0]      job_r, job_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [AVG_W-1:0]      quo_r, quo_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [AVG_W-1:0]      res_r [NUM_JOBS];
  logic [AVG_W-1:0]      res_nxt [NUM_JOBS];
  logic [LUMA_ACC_W-1:0] luma_acc_r, luma_acc_nxt;
  stats_result_t         out_r, out_nxt;

  logic                  cnt_zero;
  logic [DVS_W:0]        rem_sh;
  logic                  sub_ok;
  logic [DVS_W:0]        rem_sub;
  logic                  force_zero;
  logic [CMP_W-1:0]      two_blc;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign result    = out_r;
  assign cnt_zero  = (sums_r.quad_count == '0);
  assign two_blc   = CMP_W'({blc_cnt_r, 1'b0});

  // one restoring division step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    sub_ok  = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // results that read zero regardless of the quotient
  always_comb begin
    force_zero = cnt_zero;
    if ((job_r == JOB_RED_GAIN) && !(gain_ok_r && red_pos_r)) begin
      force_zero = 1'b1;
    end
    if ((job_r == JOB_BLUE_GAIN) && !(gain_ok_r && blue_pos_r)) begin
      force_zero = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    sums_nxt      = sums_r;
    gsum_nxt      = gsum_r;
    blc_cnt_nxt   = blc_cnt_r;
    den_nxt       = den_r;
    gain_ok_nxt   = gain_ok_r;
    red_pos_nxt   = red_pos_r;
    blue_pos_nxt  = blue_pos_r;
    red_diff_nxt  = red_diff_r;
    blue_diff_nxt = blue_diff_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    res_nxt       = res_r;
    luma_acc_nxt  = luma_acc_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sums_nxt  = sums;
          state_nxt = ST_BLC;
        end
      end

      // black level times quad count, green total
      ST_BLC: begin
        blc_cnt_nxt = BLC_CNT_W'(black_level) * BLC_CNT_W'(sums_r.quad_count);
        gsum_nxt    = GSUM_W'(sums_r.sum_green_r) + GSUM_W'(sums_r.sum_green_b);
        state_nxt   = ST_PREP;
      end

      // gain denominators and numerators
      ST_PREP: begin
        gain_ok_nxt   = (CMP_W'(gsum_r) > two_blc) && !cnt_zero;
        den_nxt       = DVS_W'(CMP_W'(gsum_r) - two_blc);
        red_pos_nxt   = CMP_W'(sums_r.sum_red) > CMP_W'(blc_cnt_r);
        blue_pos_nxt  = CMP_W'(sums_r.sum_blue) > CMP_W'(blc_cnt_r);
        red_diff_nxt  = SUM_W'(CMP_W'(sums_r.sum_red) - CMP_W'(blc_cnt_r));
        blue_diff_nxt = SUM_W'(CMP_W'(sums_r.sum_blue) - CMP_W'(blc_cnt_r));
        job_nxt       = JOB_RED;
        state_nxt     = ST_LOAD;
      end

      // operands of the next division
      ST_LOAD: begin
        dvs_nxt = DVS_W'(sums_r.quad_count);
        unique case (job_r)
          JOB_RED:       dvd_nxt = DVD_W'({sums_r.sum_red, {AVG_SHIFT{1'b0}}});
          JOB_GREEN_R:   dvd_nxt = DVD_W'({sums_r.sum_green_r, {AVG_SHIFT{1'b0}}});
          JOB_GREEN_B:   dvd_nxt = DVD_W'({sums_r.sum_green_b, {AVG_SHIFT{1'b0}}});
          JOB_BLUE:      dvd_nxt = DVD_W'({sums_r.sum_blue, {AVG_SHIFT{1'b0}}});
          JOB_GREEN:     dvd_nxt = DVD_W'({gsum_r, {GREEN_SHIFT{1'b0}}});
          JOB_RED_GAIN: begin
            dvd_nxt = DVD_W'({red_diff_r, {GAIN_SHIFT{1'b0}}}) + DVD_W'(den_r >> 1);
            dvs_nxt = den_r;
          end
          JOB_BLUE_GAIN: begin
            dvd_nxt = DVD_W'({blue_diff_r, {GAIN_SHIFT{1'b0}}}) + DVD_W'(den_r >> 1);
            dvs_nxt = den_r;
          end
          default:       dvd_nxt = '0;
        endcase
        rem_nxt   = '0;
        quo_nxt   = '0;
        ovf_nxt   = 1'b0;
        step_nxt  = STEP_W'(DVD_W - 1);
        state_nxt = ST_DIV;
      end

      // one quotient bit per cycle, saturating at the output width
      ST_DIV: begin
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        rem_nxt = sub_ok ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[AVG_W-2:0], sub_ok};
        ovf_nxt = ovf_r || quo_r[AVG_W-1];
        if (step_r == '0) begin
          if (force_zero) begin
            res_nxt[job_r] = '0;
          end else if (ovf_nxt) begin
            res_nxt[job_r] = {AVG_W{1'b1}};
          end else begin
            res_nxt[job_r] = quo_nxt;
          end
          if (job_r == JOB_BLUE_GAIN) begin
            state_nxt = ST_LUMA_R;
          end else begin
            job_nxt   = job_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end

      // luma, one weighted term per cycle
      ST_LUMA_R: begin
        luma_acc_nxt = LUMA_ACC_W'(res_r[JOB_RED]) * LUMA_ACC_W'(LUMA_WR);
        state_nxt    = ST_LUMA_G;
      end

      ST_LUMA_G: begin
        luma_acc_nxt = luma_acc_r + LUMA_ACC_W'(res_r[JOB_GREEN]) * LUMA_ACC_W'(LUMA_WG);
        state_nxt    = ST_LUMA_B;
      end

      ST_LUMA_B: begin
        luma_acc_nxt = luma_acc_r + LUMA_ACC_W'(res_r[JOB_BLUE]) * LUMA_ACC_W'(LUMA_WB)
                       + LUMA_ACC_W'(LUMA_RND);
        state_nxt    = ST_DONE;
      end

      // hand over to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.avg_red     = res_r[JOB_RED];
          out_nxt.avg_green_r = res_r[JOB_GREEN_R];
          out_nxt.avg_green_b = res_r[JOB_GREEN_B];
          out_nxt.avg_blue    = res_r[JOB_BLUE];
          out_nxt.avg_green   = res_r[JOB_GREEN];
          out_nxt.luma        = luma_acc_r[LUMA_ACC_W-1:LUMA_SHIFT];
          out_nxt.red_gain    = res_r[JOB_RED_GAIN];
          out_nxt.blue_gain   = res_r[JOB_BLUE_GAIN];
          out_nxt.quad_count  = sums_r.quad_count;
          out_nxt.gains_valid = gain_ok_r;
          out_nxt.roi_empty   = cnt_zero;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sums_r      <= sums_nxt;
    gsum_r      <= gsum_nxt;
    blc_cnt_r   <= blc_cnt_nxt;
    den_r       <= den_nxt;
    gain_ok_r   <= gain_ok_nxt;
    red_pos_r   <= red_pos_nxt;
    blue_pos_r  <= blue_pos_nxt;
    red_diff_r  <= red_diff_nxt;
    blue_diff_r <= blue_diff_nxt;
    job_r       <= job_nxt;
    step_r      <= step_nxt;
    dvd_r       <= dvd_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ovf_r       <= ovf_nxt;
    res_r       <= res_nxt;
    luma_acc_r  <= luma_acc_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/bayer_roi_color_statistics_core.sv]
// Bayer region-of-interest colour statistics for white balance.
// Input channel: one raw pixel per item with its column and row, in any
// order; end_of_frame on an item closes the frame after that pixel.
// Pixels are taken at one per cycle while the queue has room. A classifier
// writes each item into a four-entry queue; the accumulator drains one item
// per cycle into the R, Gr, Gb and B sums and the quad count.
// An end-of-frame item hands the totals to the statistics unit and clears
// the sums; pixels of the next frame keep flowing meanwhile. The unit runs
// seven 41-step bit-serial divisions plus luma weighting before its result
// goes to the output register. A further end-of-frame item waits in the
// queue while that unit is busy.
// Result channel: one item per frame from an output register; while the
// receiver stalls it holds, and the unit may already work on the next frame.
// Configuration: write roi bounds, bayer order and black level through the
// cfg port while the block is idle.
// Reset (synchronous, rst_n low): configuration and sums clear, queue and
// output empty.
`default_nettype none

module bayer_roi_color_statistics_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [brcs_pkg::PIX_W-1:0]       in_raw_pixel,
  input  wire logic [brcs_pkg::COORD_W-1:0]     in_column,
  input  wire logic [brcs_pkg::COORD_W-1:0]     in_row,
  input  wire logic                             in_end_of_frame,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [brcs_pkg::AVG_W-1:0]            out_avg_red,
  output logic [brcs_pkg::AVG_W-1:0]            out_avg_green_r,
  output logic [brcs_pkg::AVG_W-1:0]            out_avg_green_b,
  output logic [brcs_pkg::AVG_W-1:0]            out_avg_blue,
  output logic [brcs_pkg::AVG_W-1:0]            out_avg_green,
  output logic [brcs_pkg::AVG_W-1:0]            out_luma,
  output logic [brcs_pkg::AVG_W-1:0]            out_red_gain,
  output logic [brcs_pkg::AVG_W-1:0]            out_blue_gain,
  output logic [brcs_pkg::CNT_W-1:0]            out_quad_count,
  output logic                                  out_gains_valid,
  output logic                                  out_roi_empty,
  input  wire logic                             cfg_we,
  input  wire logic [brcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [brcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brcs_pkg::*;

  logic [COORD_W-1:0] roi_left_r, roi_left_nxt;
  logic [COORD_W-1:0] roi_top_r, roi_top_nxt;
  logic [COORD_W-1:0] roi_right_r, roi_right_nxt;
  logic [COORD_W-1:0] roi_bottom_r, roi_bottom_nxt;
  logic [ORDER_W-1:0] bayer_order_r, bayer_order_nxt;
  logic [BLC_W-1:0]   black_level_r, black_level_nxt;

  logic          q_push;
  logic          q_full;
  pix_item_t     q_in_item;
  logic          q_pop;
  logic          q_valid;
  pix_item_t     q_head;
  logic          st_start;
  logic          st_busy;
  frame_sums_t   st_sums;
  stats_result_t st_result;

  // configuration registers
  always_comb begin
    roi_left_nxt    = roi_left_r;
    roi_top_nxt     = roi_top_r;
    roi_right_nxt   = roi_right_r;
    roi_bottom_nxt  = roi_bottom_r;
    bayer_order_nxt = bayer_order_r;
    black_level_nxt = black_level_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROI_LEFT:    roi_left_nxt    = cfg_data[COORD_W-1:0];
        REG_ROI_TOP:     roi_top_nxt     = cfg_data[COORD_W-1:0];
        REG_ROI_RIGHT:   roi_right_nxt   = cfg_data[COORD_W-1:0];
        REG_ROI_BOTTOM:  roi_bottom_nxt  = cfg_data[COORD_W-1:0];
        REG_BAYER_ORDER: bayer_order_nxt = cfg_data[ORDER_W-1:0];
        REG_BLACK_LEVEL: black_level_nxt = cfg_data[BLC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_left_r    <= '0;
      roi_top_r     <= '0;
      roi_right_r   <= '0;
      roi_bottom_r  <= '0;
      bayer_order_r <= '0;
      black_level_r <= '0;
    end else begin
      roi_left_r    <= roi_left_nxt;
      roi_top_r     <= roi_top_nxt;
      roi_right_r   <= roi_right_nxt;
      roi_bottom_r  <= roi_bottom_nxt;
      bayer_order_r <= bayer_order_nxt;
      black_level_r <= black_level_nxt;
    end
  end

  // classifier
  brcs_front u_front (
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_pixel    (in_raw_pixel),
    .column       (in_column),
    .row          (in_row),
    .end_of_frame (in_end_of_frame),
    .roi_left     (roi_left_r),
    .roi_top      (roi_top_r),
    .roi_right    (roi_right_r),
    .roi_bottom   (roi_bottom_r),
    .bayer_order  (bayer_order_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in_item)
  );

  // item queue
  brcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_item  (q_head),
    .head_valid (q_valid)
  );

  // channel sums
  brcs_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .st_busy  (st_busy),
    .st_start (st_start),
    .st_sums  (st_sums)
  );

  // per-frame averages and gains
  brcs_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (st_start),
    .sums        (st_sums),
    .black_level (black_level_r),
    .busy        (st_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (st_result)
  );

  assign out_avg_red     = st_result.avg_red;
  assign out_avg_green_r = st_result.avg_green_r;
  assign out_avg_green_b = st_result.avg_green_b;
  assign out_avg_blue    = st_result.avg_blue;
  assign out_avg_green   = st_result.avg_green;
  assign out_luma        = st_result.luma;
  assign out_red_gain    = st_result.red_gain;
  assign out_blue_gain   = st_result.blue_gain;
  assign out_quad_count  = st_result.quad_count;
  assign out_gains_valid = st_result.gains_valid;
  assign out_roi_empty   = st_result.roi_empty;

  // frame totals only go to an idle statistics unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_start |-> !st_busy)
    else $error("frame totals handed over while statistics unit busy");

  // gains read zero when not valid
  a_gain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_gains_valid) |-> (out_red_gain == '0 && out_blue_gain == '0))
    else $error("gain non-zero while gains flagged invalid");

  // empty region gives zero statistics
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_roi_empty) |->
      (out_avg_red == '0 && out_avg_green == '0 && out_avg_blue == '0 &&
       out_luma == '0 && out_quad_count == '0 && !out_gains_valid))
    else $error("empty region reported with non-zero statistics");

endmodule

`default_nettype wire
